// ----- rtl/dra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS reply A-record extractor: shared definitions
// Field widths, status codes, parse phases and the request record that passes
// from the input register to the parser.
// ----------------------------------------------------------------------------
package dra_pkg;

    localparam int BYTE_W    = 8;
    localparam int ID_W      = 16;
    localparam int COUNT_W   = 16;
    localparam int ADDR_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int HDR_POS_W = 4;

    localparam int HEADER_BYTES  = 12;
    localparam int Q_FIXED_BYTES = 4;
    localparam int A_FIXED_BYTES = 10;
    localparam int A_RDATA_BYTES = 4;
    localparam int TYPE_A        = 1;

    localparam logic [BYTE_W-1:0] PTR_MASK   = 8'hC0;
    localparam logic [BYTE_W-1:0] RCODE_MASK = 8'h0F;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_SHORT    = 3'd0,
        STATUS_MISMATCH = 3'd1,
        STATUS_SERVFAIL = 3'd2,
        STATUS_FOUND    = 3'd3,
        STATUS_NO_ADDR  = 3'd4
    } t_status;

    typedef enum logic [14:0] {
        PH_HEADER   = 15'b000000000000001,
        PH_Q_NAME   = 15'b000000000000010,
        PH_Q_LABEL  = 15'b000000000000100,
        PH_Q_PTR    = 15'b000000000001000,
        PH_Q_FIXED  = 15'b000000000010000,
        PH_A_NAME   = 15'b000000000100000,
        PH_A_LABEL  = 15'b000000001000000,
        PH_A_PTR    = 15'b000000010000000,
        PH_A_FIXED  = 15'b000000100000000,
        PH_A_RDATA  = 15'b000001000000000,
        PH_A_SKIP   = 15'b000010000000000,
        PH_MISMATCH = 15'b000100000000000,
        PH_ERROR    = 15'b001000000000000,
        PH_FOUND    = 15'b010000000000000,
        PH_NONE     = 15'b100000000000000
    } t_phase;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_byte_req;

endpackage
`default_nettype wire

// ----- rtl/dra_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS reply A-record extractor: channel interfaces
// Valid/ready channels for reply bytes and for the per-message result.
// ----------------------------------------------------------------------------
interface dra_byte_if import dra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dra_result_if import dra_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address;

    modport source (output valid, output status, output address, input ready);
    modport sink   (input valid, input status, input address, output ready);
endinterface
`default_nettype wire

// ----- rtl/dra_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS reply A-record extractor: input register
// Holds one reply byte until the parser takes it.
// ----------------------------------------------------------------------------
module dra_in_stage import dra_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    dra_byte_if.sink   i_in,
    input  wire        i_consume,
    output t_byte_req  o_req
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              accept;

    assign i_in.ready = !r_valid || i_consume;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_consume) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last_byte;
        end
    end

    assign o_req.valid     = r_valid;
    assign o_req.data_byte = r_byte;
    assign o_req.last_byte = r_last;

endmodule
`default_nettype wire

// ----- rtl/dra_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS reply A-record extractor: parser
// Walks the header, questions and answers one byte per request and registers
// the status and address when the final byte of a reply is taken.
// ----------------------------------------------------------------------------
module dra_parser import dra_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [ID_W-1:0]   i_cfg_wdata,
    input  t_byte_req         i_req,
    output logic              o_consume,
    dra_result_if.source      o_out
);

    localparam logic [HDR_POS_W-1:0] POS_ID_HI = 4'd0;
    localparam logic [HDR_POS_W-1:0] POS_ID_LO = 4'd1;
    localparam logic [HDR_POS_W-1:0] POS_FLAGS = 4'd3;
    localparam logic [HDR_POS_W-1:0] POS_QD_HI = 4'd4;
    localparam logic [HDR_POS_W-1:0] POS_QD_LO = 4'd5;
    localparam logic [HDR_POS_W-1:0] POS_AN_HI = 4'd6;
    localparam logic [HDR_POS_W-1:0] POS_AN_LO = 4'd7;
    localparam logic [HDR_POS_W-1:0] POS_LAST  = HDR_POS_W'(HEADER_BYTES - 1);

    localparam logic [COUNT_W-1:0] SKIP_ONE   = 16'd1;
    localparam logic [COUNT_W-1:0] SKIP_Q_FIX = COUNT_W'(Q_FIXED_BYTES);
    localparam logic [COUNT_W-1:0] SKIP_A_FIX = COUNT_W'(A_FIXED_BYTES);
    localparam logic [COUNT_W-1:0] SKIP_RDATA = COUNT_W'(A_RDATA_BYTES);
    localparam logic [COUNT_W-1:0] SKIP_TYPE0 = COUNT_W'(A_FIXED_BYTES);
    localparam logic [COUNT_W-1:0] SKIP_TYPE1 = COUNT_W'(A_FIXED_BYTES - 1);
    localparam logic [COUNT_W-1:0] SKIP_LEN0  = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] TYPE_A_VAL = COUNT_W'(TYPE_A);

    logic [ID_W-1:0]      r_expected_id;
    t_phase               r_phase, n_phase, step_phase;
    logic [HDR_POS_W-1:0] r_hdr_pos, n_hdr_pos;
    logic [ID_W-1:0]      r_reply_id, n_reply_id;
    logic [3:0]           r_rcode, n_rcode;
    logic [COUNT_W-1:0]   r_questions, n_questions;
    logic [COUNT_W-1:0]   r_answers, n_answers;
    logic [COUNT_W-1:0]   r_skip, n_skip;
    logic [COUNT_W-1:0]   r_rtype, n_rtype;
    logic [COUNT_W-1:0]   r_rdlen, n_rdlen;
    logic [ADDR_W-1:0]    r_acc, n_acc;

    logic                 r_out_valid;
    t_status              r_status, res_status;
    logic [ADDR_W-1:0]    r_address, res_address;

    logic [BYTE_W-1:0]    b;
    logic                 is_ptr;
    logic [COUNT_W-1:0]   skip_dec;
    logic [COUNT_W-1:0]   q_dec, a_dec;
    logic                 end_msg;

    assign b         = i_req.data_byte;
    assign is_ptr    = (b & PTR_MASK) == PTR_MASK;
    assign skip_dec  = r_skip - SKIP_ONE;
    assign q_dec     = r_questions - SKIP_ONE;
    assign a_dec     = r_answers - SKIP_ONE;
    // A non-final byte always moves on; a final byte needs a free result slot.
    assign o_consume = i_req.valid && (!i_req.last_byte || !r_out_valid || o_out.ready);
    assign end_msg   = o_consume && i_req.last_byte;

    always_comb begin
        step_phase  = r_phase;
        n_hdr_pos   = r_hdr_pos;
        n_reply_id  = r_reply_id;
        n_rcode     = r_rcode;
        n_questions = r_questions;
        n_answers   = r_answers;
        n_skip      = r_skip;
        n_rtype     = r_rtype;
        n_rdlen     = r_rdlen;
        n_acc       = r_acc;

        if (o_consume) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_hdr_pos = r_hdr_pos + 4'd1;
                    unique case (r_hdr_pos)
                        POS_ID_HI: n_reply_id[15:8]  = b;
                        POS_ID_LO: n_reply_id[7:0]   = b;
                        POS_FLAGS: n_rcode           = b[3:0] & RCODE_MASK[3:0];
                        POS_QD_HI: n_questions[15:8] = b;
                        POS_QD_LO: n_questions[7:0]  = b;
                        POS_AN_HI: n_answers[15:8]   = b;
                        POS_AN_LO: n_answers[7:0]    = b;
                        default: ;
                    endcase
                    if (r_hdr_pos == POS_LAST) begin
                        // The id is checked before the response code.
                        if (r_reply_id != r_expected_id) begin
                            step_phase = PH_MISMATCH;
                        end else if (r_rcode != 4'd0) begin
                            step_phase = PH_ERROR;
                        end else if (r_questions != '0) begin
                            step_phase = PH_Q_NAME;
                        end else begin
                            step_phase = (r_answers != '0) ? PH_A_NAME : PH_NONE;
                        end
                    end
                end
                PH_Q_NAME, PH_A_NAME: begin
                    if (is_ptr) begin
                        step_phase = (r_phase == PH_Q_NAME) ? PH_Q_PTR : PH_A_PTR;
                    end else if (b == '0) begin
                        n_skip     = (r_phase == PH_Q_NAME) ? SKIP_Q_FIX : SKIP_A_FIX;
                        step_phase = (r_phase == PH_Q_NAME) ? PH_Q_FIXED : PH_A_FIXED;
                    end else begin
                        n_skip     = {8'd0, b};
                        step_phase = (r_phase == PH_Q_NAME) ? PH_Q_LABEL : PH_A_LABEL;
                    end
                end
                PH_Q_LABEL, PH_A_LABEL: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        step_phase = (r_phase == PH_Q_LABEL) ? PH_Q_NAME : PH_A_NAME;
                    end
                end
                PH_Q_PTR: begin
                    n_skip     = SKIP_Q_FIX;
                    step_phase = PH_Q_FIXED;
                end
                PH_Q_FIXED: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_questions = q_dec;
                        if (q_dec != '0) begin
                            step_phase = PH_Q_NAME;
                        end else begin
                            step_phase = (r_answers != '0) ? PH_A_NAME : PH_NONE;
                        end
                    end
                end
                PH_A_PTR: begin
                    n_skip     = SKIP_A_FIX;
                    step_phase = PH_A_FIXED;
                end
                PH_A_FIXED: begin
                    // The countdown tells which of the ten fixed bytes this is.
                    if (r_skip == SKIP_TYPE0) n_rtype[15:8] = b;
                    if (r_skip == SKIP_TYPE1) n_rtype[7:0]  = b;
                    if (r_skip == SKIP_LEN0)  n_rdlen[15:8] = b;
                    if (r_skip == SKIP_ONE)   n_rdlen[7:0]  = b;
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        if (n_rtype == TYPE_A_VAL && n_rdlen == SKIP_RDATA) begin
                            n_skip     = SKIP_RDATA;
                            n_acc      = '0;
                            step_phase = PH_A_RDATA;
                        end else if (n_rdlen != '0) begin
                            n_skip     = n_rdlen;
                            step_phase = PH_A_SKIP;
                        end else begin
                            n_answers  = a_dec;
                            step_phase = (a_dec != '0) ? PH_A_NAME : PH_NONE;
                        end
                    end
                end
                PH_A_RDATA: begin
                    n_acc  = {r_acc[ADDR_W-BYTE_W-1:0], b};
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        step_phase = PH_FOUND;
                    end
                end
                PH_A_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_answers  = a_dec;
                        step_phase = (a_dec != '0) ? PH_A_NAME : PH_NONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res_address = '0;
        unique case (step_phase)
            PH_HEADER:   res_status = STATUS_SHORT;
            PH_MISMATCH: res_status = STATUS_MISMATCH;
            PH_ERROR:    res_status = STATUS_SERVFAIL;
            PH_FOUND: begin
                res_status  = STATUS_FOUND;
                res_address = n_acc;
            end
            default:     res_status = STATUS_NO_ADDR;
        endcase
    end

    // A finished reply returns the walk to the start of the header.
    assign n_phase = end_msg ? PH_HEADER : step_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= '0;
            r_phase       <= PH_HEADER;
            r_hdr_pos     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_expected_id <= i_cfg_wdata;
            end
            r_phase   <= n_phase;
            r_hdr_pos <= end_msg ? '0 : n_hdr_pos;
            if (end_msg) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_reply_id  <= n_reply_id;
        r_rcode     <= n_rcode;
        r_questions <= n_questions;
        r_answers   <= n_answers;
        r_skip      <= n_skip;
        r_rtype     <= n_rtype;
        r_rdlen     <= n_rdlen;
        r_acc       <= n_acc;
        if (end_msg) begin
            r_status  <= res_status;
            r_address <= res_address;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.status  = r_status;
    assign o_out.address = r_address;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status <= STATUS_NO_ADDR))
        else $error("result status outside the defined codes");

    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_hdr_pos <= POS_LAST))
        else $error("header position ran past the header");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_msg |=> (r_phase == PH_HEADER && r_hdr_pos == '0 && r_out_valid))
        else $error("parser did not restart after the final byte");

    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (end_msg && step_phase == PH_FOUND) |=> (r_status == STATUS_FOUND))
        else $error("address found but not reported");

endmodule
`default_nettype wire

// ----- rtl/dns_reply_a_record_extract.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS reply A-record extractor
// Parses a DNS reply byte by byte and reports the first IPv4 address found.
// ----------------------------------------------------------------------------
// The block takes one reply byte per cycle on i_in while no final byte waits,
// with last_byte marking the end of the message, and returns one result on
// o_out per message: a status (short, id mismatch, server error, address
// found, no address) and the address, which is zero unless the status is
// address found. Each byte passes through an input register and then one step
// of the parser's phase logic; the result is registered when the parser
// takes the final byte, once no earlier result is still waiting.
// Non-final bytes keep flowing while a result waits; a final byte is held in
// the input register until the previous result has been taken. i_cfg_we
// writes the expected transaction id and should only be used between messages.
module dns_reply_a_record_extract import dra_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [ID_W-1:0]  i_cfg_wdata,
    dra_byte_if.sink         i_in,
    dra_result_if.source     o_out
);

    t_byte_req req;
    logic      consume;

    dra_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_consume (consume),
        .o_req     (req)
    );

    dra_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req),
        .o_consume   (consume),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
